[sv/ogp_pkg.sv]
// Shared types, codes and helpers of the occupancy grid projection block
package ogp_pkg;

  localparam int COORD_W = 10;
  localparam int VAL_W   = 16;
  localparam int SIDE_W  = 8;
  localparam int IDX_W   = 3;
  localparam int STATE_W = 8;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_VOXEL  = 2'd1,
    OP_SQUARE = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CELL_UNKNOWN  = 2'd0,
    CELL_FREE     = 2'd1,
    CELL_OCCUPIED = 2'd2
  } cell_t;

  typedef enum logic [IDX_W-1:0] {
    REG_OCC_TH   = 3'd0,
    REG_FREE_TH  = 3'd1,
    REG_FLOOR    = 3'd2,
    REG_CEILING  = 3'd3,
    REG_MAX_SIDE = 3'd4
  } reg_idx_t;

  localparam logic signed [STATE_W-1:0] CODE_UNKNOWN  = -8'sd1;
  localparam logic signed [STATE_W-1:0] CODE_FREE     = 8'sd0;
  localparam logic signed [STATE_W-1:0] CODE_OCCUPIED = 8'sd100;

  typedef struct packed {
    logic signed [VAL_W-1:0] occ_th;
    logic signed [VAL_W-1:0] free_th;
    logic signed [VAL_W-1:0] floor_mm;
    logic signed [VAL_W-1:0] ceiling_mm;
    logic [SIDE_W-1:0]       max_side;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic rd_in;
    logic rd_sq;
    logic clr_wr;
    logic vox_wr;
    logic sq_wr;
    logic sq_adv;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic sq_go;
    logic sq_last;
  } sts_t;

  function automatic logic signed [STATE_W-1:0] cell_code(input logic [1:0] c);
    logic signed [STATE_W-1:0] r;
    r = CODE_UNKNOWN;
    if (c == CELL_OCCUPIED) r = CODE_OCCUPIED;
    else if (c == CELL_FREE) r = CODE_FREE;
    return r;
  endfunction

endpackage

[sv/occupancy_grid_projection.sv]
// Top level of the occupancy grid projection block
// Keeps a GRID_SIDE x GRID_SIDE grid of unknown, free or occupied cells.
// Requests: raise start with the in_ fields; a request is taken at a clock
// edge where start is high and busy is low. op selects clear, voxel update,
// free square or cell read.
// Results: only a read request answers; out_cell_state is valid for one
// cycle with out_strobe high, registered in the read state once the request
// is taken. The receiver cannot stall, so results are never held.
// Request lengths are set by the single-port grid memory read-modify-write:
// a voxel update or read reads its cell when taken, then writes or answers;
// a free square reads each cell inside the grid and writes it free if unknown,
// ending at once when it touches no cell; a clear writes every cell unknown.
// Reset: the configuration takes its reset values and a clearing pass marks
// every cell unknown; busy stays high until it ends. Configuration writes
// (cfg_valid, cfg_index, cfg_data) are always taken, and are meant to happen
// while the block is idle.
module occupancy_grid_projection #(
  parameter int GRID_SIDE       = 256,
  parameter int MAX_SQUARE_SIDE = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_op,
  input  logic [ogp_pkg::COORD_W-1:0]        in_cell_x,
  input  logic [ogp_pkg::COORD_W-1:0]        in_cell_y,
  input  logic signed [ogp_pkg::VAL_W-1:0]   in_height_mm,
  input  logic signed [ogp_pkg::VAL_W-1:0]   in_occupancy_value,
  input  logic [ogp_pkg::SIDE_W-1:0]         in_square_side,
  output logic signed [ogp_pkg::STATE_W-1:0] out_cell_state,
  output logic                               out_strobe,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ogp_pkg::IDX_W-1:0]          cfg_index,
  input  logic [ogp_pkg::VAL_W-1:0]          cfg_data
);

  ogp_pkg::cfg_t cfg;
  ogp_pkg::cmd_t cmd;
  ogp_pkg::sts_t sts;

  ogp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ogp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  ogp_dp #(
    .GRID_SIDE       (GRID_SIDE),
    .MAX_SQUARE_SIDE (MAX_SQUARE_SIDE)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_cell_x          (in_cell_x),
    .in_cell_y          (in_cell_y),
    .in_height_mm       (in_height_mm),
    .in_occupancy_value (in_occupancy_value),
    .in_square_side     (in_square_side),
    .cfg                (cfg),
    .cmd                (cmd),
    .sts                (sts),
    .out_cell_state     (out_cell_state),
    .out_strobe         (out_strobe)
  );

  a_strobe_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(cmd.emit))
    else $error("result strobe without a read");

  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr_wr, cmd.vox_wr, cmd.sq_wr}))
    else $error("more than one grid write source");

  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request taken without going busy");

  a_strobe_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("results on adjacent cycles");

endmodule

[sv/ogp_cfg.sv]
// Configuration register file of the occupancy grid projection block
module ogp_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ogp_pkg::IDX_W-1:0]    cfg_index,
  input  logic [ogp_pkg::VAL_W-1:0]    cfg_data,
  output ogp_pkg::cfg_t                cfg
);

  ogp_pkg::cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        ogp_pkg::REG_OCC_TH:   cfg_nxt.occ_th     = cfg_data;
        ogp_pkg::REG_FREE_TH:  cfg_nxt.free_th    = cfg_data;
        ogp_pkg::REG_FLOOR:    cfg_nxt.floor_mm   = cfg_data;
        ogp_pkg::REG_CEILING:  cfg_nxt.ceiling_mm = cfg_data;
        ogp_pkg::REG_MAX_SIDE: cfg_nxt.max_side   = cfg_data[ogp_pkg::SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.occ_th     <= 16'sd128;
      cfg_r.free_th    <= -16'sd128;
      cfg_r.floor_mm   <= -16'sd1000;
      cfg_r.ceiling_mm <= 16'sd2000;
      cfg_r.max_side   <= 8'd64;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[sv/ogp_ctrl.sv]
// Sequencing state machine of the occupancy grid projection block
module ogp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [1:0]           in_op,
  input  ogp_pkg::sts_t        sts,
  output logic                 busy,
  output ogp_pkg::cmd_t        cmd
);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_VOX    = 6'b000100,
    S_SQ_RD  = 6'b001000,
    S_SQ_WR  = 6'b010000,
    S_READ   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          cmd.rd_in = 1'b1;
          unique case (in_op)
            ogp_pkg::OP_CLEAR:  state_nxt = S_CLEAR;
            ogp_pkg::OP_VOXEL:  state_nxt = S_VOX;
            ogp_pkg::OP_SQUARE: state_nxt = S_SQ_RD;
            ogp_pkg::OP_READ:   state_nxt = S_READ;
            default:            state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_VOX: begin
        cmd.vox_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_SQ_RD: begin
        if (sts.sq_go) begin
          cmd.rd_sq = 1'b1;
          state_nxt = S_SQ_WR;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SQ_WR: begin
        cmd.sq_wr  = 1'b1;
        cmd.sq_adv = 1'b1;
        state_nxt  = sts.sq_last ? S_IDLE : S_SQ_RD;
      end
      S_READ: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/ogp_dp.sv]
// Grid memory, request registers, square cursor and sweep counter
module ogp_dp #(
  parameter int GRID_SIDE       = 256,
  parameter int MAX_SQUARE_SIDE = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [ogp_pkg::COORD_W-1:0]       in_cell_x,
  input  logic [ogp_pkg::COORD_W-1:0]       in_cell_y,
  input  logic signed [ogp_pkg::VAL_W-1:0]  in_height_mm,
  input  logic signed [ogp_pkg::VAL_W-1:0]  in_occupancy_value,
  input  logic [ogp_pkg::SIDE_W-1:0]        in_square_side,
  input  ogp_pkg::cfg_t                     cfg,
  input  ogp_pkg::cmd_t                     cmd,
  output ogp_pkg::sts_t                     sts,
  output logic signed [ogp_pkg::STATE_W-1:0] out_cell_state,
  output logic                              out_strobe
);

  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int EW    = ogp_pkg::COORD_W + 1;
  localparam int PW    = 2 * ogp_pkg::COORD_W + 1;
  localparam logic [EW-1:0] GSIDE = EW'(GRID_SIDE);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [ogp_pkg::SIDE_W-1:0] MAX_SIDE = ogp_pkg::SIDE_W'(MAX_SQUARE_SIDE);

  logic [1:0] mem [CELLS];

  logic [ogp_pkg::COORD_W-1:0]      x_r, y_r, cx_r, cy_r;
  logic signed [ogp_pkg::VAL_W-1:0] h_r, v_r;
  logic [ogp_pkg::SIDE_W-1:0]       side_r;
  logic [AW-1:0]                    clr_cnt_r, rd_addr_r;
  logic [1:0]                       rd_data_r;
  logic signed [ogp_pkg::STATE_W-1:0] out_state_r;
  logic                             out_strobe_r;

  logic [EW-1:0]  xe, ye, x_sum, y_sum, cx_inc, cy_inc;
  logic [AW-1:0]  in_addr, sq_addr, rd_addr, wr_addr;
  logic           rd_en, we, in_grid, vox_ok, sq_ok, sq_empty, x_wrap;
  logic           set_occ, set_free;
  logic [1:0]     wr_data;

  function automatic logic [AW-1:0] cell_addr(input logic [ogp_pkg::COORD_W-1:0] x,
                                               input logic [ogp_pkg::COORD_W-1:0] y);
    logic [PW-1:0] p;
    p = PW'(y) * PW'(GRID_SIDE) + PW'(x);
    return p[AW-1:0];
  endfunction

  assign in_addr = cell_addr(in_cell_x, in_cell_y);
  assign sq_addr = cell_addr(cx_r, cy_r);
  assign rd_en   = cmd.rd_in | cmd.rd_sq;
  assign rd_addr = cmd.rd_sq ? sq_addr : in_addr;

  assign in_grid = (EW'(x_r) < GSIDE) && (EW'(y_r) < GSIDE);
  assign vox_ok  = in_grid && (h_r < cfg.ceiling_mm) && (h_r > cfg.floor_mm);
  assign set_occ = v_r > cfg.occ_th;
  assign set_free = (v_r < cfg.free_th) && (rd_data_r == ogp_pkg::CELL_UNKNOWN);

  assign x_sum = EW'(x_r) + EW'(side_r);
  assign y_sum = EW'(y_r) + EW'(side_r);
  assign xe    = (x_sum > GSIDE) ? GSIDE : x_sum;
  assign ye    = (y_sum > GSIDE) ? GSIDE : y_sum;
  assign sq_ok = (v_r < 0) && (side_r <= cfg.max_side) && (side_r <= MAX_SIDE);
  assign sq_empty = (EW'(x_r) >= xe) || (EW'(y_r) >= ye);
  assign cx_inc = EW'(cx_r) + EW'(1);
  assign cy_inc = EW'(cy_r) + EW'(1);
  assign x_wrap = (cx_inc == xe);

  assign sts.clr_last = (clr_cnt_r == LAST_CELL);
  assign sts.sq_go    = sq_ok && !sq_empty;
  assign sts.sq_last  = x_wrap && (cy_inc == ye);

  always_comb begin
    we      = 1'b0;
    wr_addr = rd_addr_r;
    wr_data = ogp_pkg::CELL_FREE;
    priority if (cmd.clr_wr) begin
      we      = 1'b1;
      wr_addr = clr_cnt_r;
      wr_data = ogp_pkg::CELL_UNKNOWN;
    end else if (cmd.vox_wr) begin
      we      = vox_ok && (set_occ || set_free);
      wr_data = set_occ ? ogp_pkg::CELL_OCCUPIED : ogp_pkg::CELL_FREE;
    end else if (cmd.sq_wr) begin
      we      = (rd_data_r == ogp_pkg::CELL_UNKNOWN);
    end else begin
      we      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r    <= in_cell_x;
      y_r    <= in_cell_y;
      h_r    <= in_height_mm;
      v_r    <= in_occupancy_value;
      side_r <= in_square_side;
      cx_r   <= in_cell_x;
      cy_r   <= in_cell_y;
    end else if (cmd.sq_adv) begin
      if (x_wrap) begin
        cx_r <= x_r;
        cy_r <= cy_inc[ogp_pkg::COORD_W-1:0];
      end else begin
        cx_r <= cx_inc[ogp_pkg::COORD_W-1:0];
      end
    end
    if (cmd.emit) begin
      out_state_r <= in_grid ? ogp_pkg::cell_code(rd_data_r) : ogp_pkg::CODE_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit;
      if (cmd.load) clr_cnt_r <= '0;
      else if (cmd.clr_wr) clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  assign out_cell_state = out_state_r;
  assign out_strobe     = out_strobe_r;

endmodule
